// ===== rtl/sdsb_pkg.sv =====
// Shared types and constants for the sorted distinct set builder.
// No dependencies; used by the cell, the top level and the checker.
package sdsb_pkg;

   localparam int SDSB_CAPACITY = 32;
   localparam int SDSB_WORD_W   = 32;

   // What one cell hands to its neighbors.
   typedef struct packed {
      logic                   valid;
      logic                   gt;     // holds a value above the sample, or is empty
      logic [SDSB_WORD_W-1:0] value;
   } sdsb_link_type;

   // Chain-wide controls, same for every cell.
   typedef struct packed {
      logic insert;     // place the sample in sorted order
      logic shift_out;  // move every entry one cell toward the head
   } sdsb_ctrl_type;

endpackage

// ===== rtl/sdsb_cell.sv =====
// One cell of the sorted insertion chain: a valid bit and one stored value.
// Depends on sdsb_pkg for the link and control structs.
module sdsb_cell
   import sdsb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  sdsb_ctrl_type                 ctrl,
   input  logic signed [SDSB_WORD_W-1:0] sample,
   input  sdsb_link_type                 left_link,
   input  sdsb_link_type                 right_link,
   output sdsb_link_type                 out_link,
   output logic                          eq
);

   logic                   valid_ff, valid_in;
   logic [SDSB_WORD_W-1:0] value_ff, value_in;
   logic                   gt;

   assign gt = !valid_ff || ($signed(value_ff) > sample);
   assign eq = valid_ff && ($signed(value_ff) == sample);

   assign out_link.valid = valid_ff;
   assign out_link.gt    = gt;
   assign out_link.value = value_ff;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.insert) begin
         if (gt) begin
            // first cell above the sample takes it, the rest take the left value
            value_in = left_link.gt ? left_link.value : sample;
            valid_in = valid_ff | left_link.valid;
         end
      end else if (ctrl.shift_out) begin
         value_in = right_link.value;
         valid_in = right_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/sorted_distinct_set_builder_core.sv =====
// A value transaction is absorbed in the cycle it is accepted; one per cycle while idle.
// After an end-of-set transaction the run starts the next cycle: the count, then n
// values, one result per cycle while rsp_tready is high (n <= CAPACITY).
// The input side is stalled while the run drains; the chain shifts one cell a result.
// Reset (synchronous, active high) empties the chain, zeroes count and overflow flag.
module sorted_distinct_set_builder_core
   import sdsb_pkg::*;
#(
   parameter int CAPACITY = SDSB_CAPACITY
)(
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SDSB_WORD_W-1:0] req_tdata,   // [31:0] sample_value
   input  logic [0:0]             req_tuser,   // [0] has_value
   input  logic                   req_tlast,   // end_of_set
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SDSB_WORD_W-1:0] rsp_tdata,   // [31:0] out_word
   output logic [1:0]             rsp_tuser,   // [0] is_count, [1] overflowed
   output logic                   rsp_tlast    // last_result
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // controller states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_DATA  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   sdsb_link_type    link [CAPACITY];
   logic [CAPACITY-1:0] eq_vec;
   sdsb_ctrl_type    ctrl;

   logic req_fire, rsp_fire;
   logic dup, full, head_last, run_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // A duplicate sits right before the insertion point; any matching cell blocks the insert.
   assign dup  = |eq_vec;
   assign full = link[CAPACITY-1].valid;

   assign ctrl.insert    = req_fire && req_tuser[0] && !dup && !full;
   assign ctrl.shift_out = (state_ff == ST_DATA) && rsp_tready;

   // ---------------- cell chain ----------------
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         sdsb_link_type left_l, right_l;
         if (gi == 0) begin : g_head
            // head sees a full, non-greater left neighbor
            assign left_l = '{valid: 1'b1, gt: 1'b0, value: '0};
         end else begin : g_mid
            assign left_l = link[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_tail
            assign right_l = '{valid: 1'b0, gt: 1'b1, value: '0};
         end else begin : g_body
            assign right_l = link[gi+1];
         end
         sdsb_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .sample     ($signed(req_tdata)),
            .left_link  (left_l),
            .right_link (right_l),
            .out_link   (link[gi]),
            .eq         (eq_vec[gi])
         );
      end
      // the head value is the last of the run once the cell behind it is empty
      if (CAPACITY > 1) begin : g_last_multi
         assign head_last = !link[1].valid;
      end else begin : g_last_single
         assign head_last = 1'b1;
      end
   endgenerate

   // ---------------- result side ----------------
   always_comb begin
      rsp_tvalid = 1'b0;
      rsp_tdata  = link[0].value;
      rsp_tuser  = {ovf_ff, 1'b0};
      rsp_tlast  = head_last;
      unique case (state_ff)
         ST_IDLE: begin
            rsp_tvalid = 1'b0;
         end
         ST_COUNT: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = {{(SDSB_WORD_W-CNT_W){1'b0}}, count_ff};
            rsp_tuser  = {ovf_ff, 1'b1};
            rsp_tlast  = (count_ff == '0);
         end
         ST_DATA: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   assign run_done = rsp_fire && rsp_tlast;

   // ---------------- controller ----------------
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end
      if (req_fire && req_tuser[0] && !dup && full) begin
         ovf_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tlast) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (rsp_fire) begin
               state_in = rsp_tlast ? ST_IDLE : ST_DATA;
            end
         end
         ST_DATA: begin
            if (run_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (run_done) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== rtl/sdsb_checker.sv =====
// Port-level checks for the sorted distinct set builder, bound to the top level.
// Depends on sdsb_pkg for the word width.
module sdsb_checker
   import sdsb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [SDSB_WORD_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   // input side is stalled whenever a result is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while a result is pending");

   // an end-of-set transaction is followed by the count
   a_count_first: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> (rsp_tvalid && rsp_tuser[0]))
      else $error("run did not open with the count");

   // after the final result the block is ready for a new set
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after the last result");

   // an empty set is a single result
   a_empty_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] && (rsp_tdata == '0)) |-> rsp_tlast)
      else $error("zero count not marked last");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind sorted_distinct_set_builder_core sdsb_checker u_sdsb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
